@@ rtl/process_slice_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// Process slice scheduler assertion macros
// Shared assertion shorthands for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef PROCESS_SLICE_SCHEDULER_DEFINES_SVH
`define PROCESS_SLICE_SCHEDULER_DEFINES_SVH

// implication checked at every rising clock edge outside reset
`define PSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbl failed");

// implication whose consequent is checked in the cycle after the antecedent
`define PSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

@@ rtl/pss_pkg.sv @@
// ----------------------------------------------------------------------------
// Process slice scheduler package
// Codes, widths and command types shared by controller and datapath.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] POL_RR   = 2'd0;
  localparam logic [1:0] POL_FIFO = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_RAN     = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_RESTART = 3'd4;

  localparam logic [0:0] CFG_POLICY  = 1'b0;
  localparam logic [0:0] CFG_QUANTUM = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic add;       // write new entry at tail
    logic restart;   // clear switch count
    logic scan;      // compare one slot
    logic take;      // latch picked entry
    logic shift;     // move one slot toward head
    logic finish;    // compute slice, requeue, update counters
    logic show;      // load output registers
  } pss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic shift_last;
  } pss_sts_t;

endpackage

@@ rtl/pss_datapath.sv @@
// ----------------------------------------------------------------------------
// Process slice scheduler datapath
// Ready queue storage, priority scan, queue compaction and slice arithmetic.
// ----------------------------------------------------------------------------
`include "process_slice_scheduler_defines.svh"

module pss_datapath #(
  parameter int QUEUE_DEPTH = pss_pkg::QUEUE_DEPTH_DEF,
  localparam int IW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pss_pkg::pss_cmd_t cmd,
  output pss_pkg::pss_sts_t sts,
  input  logic [1:0]       policy_mode,
  input  logic [15:0]      time_quantum,
  input  logic [1:0]       in_action,
  input  logic [7:0]       in_process_id,
  input  logic [15:0]      in_arrival_time,
  input  logic [15:0]      in_burst_time,
  input  logic [2:0]       in_proc_priority,
  output logic [2:0]       out_status,
  output logic [7:0]       out_run_id,
  output logic [31:0]      out_slice_start,
  output logic [15:0]      out_slice_length,
  output logic [15:0]      out_time_left,
  output logic             out_finished,
  output logic signed [32:0] out_wait_time,
  output logic signed [32:0] out_turnaround,
  output logic [15:0]      out_switch_count,
  output logic [CW-1:0]    out_queue_count
);

  logic [7:0]  ident_r   [QUEUE_DEPTH];
  logic [15:0] arrival_r [QUEUE_DEPTH];
  logic [15:0] remain_r  [QUEUE_DEPTH];
  logic [2:0]  rank_r    [QUEUE_DEPTH];
  logic        started_r [QUEUE_DEPTH];
  logic [32:0] wait_r    [QUEUE_DEPTH];

  logic [CW-1:0] occ_r;
  logic [31:0]   clock_r;
  logic [15:0]   switches_r;
  logic [CW-1:0] occ_nxt;
  logic [15:0]   switches_nxt;

  logic [1:0]  act_r;
  logic [7:0]  pid_r;
  logic [15:0] arr_in_r, burst_r;
  logic [2:0]  prio_r;

  logic [IW-1:0] scan_r, pick_r, sh_r;
  logic [2:0]    best_r;

  logic [7:0]  p_id_r;
  logic [15:0] p_arr_r, p_rem_r;
  logic [2:0]  p_rank_r;
  logic [32:0] p_wait_r;

  logic [15:0] quant;
  logic [15:0] run;
  logic [32:0] clk_sum;
  logic [31:0] clk_new;
  logic [15:0] rem_new;
  logic        done;
  logic [IW-1:0] tail;
  logic [IW-1:0] sh_next;
  logic [CW-1:0] occ_dec;

  assign quant   = (time_quantum == 16'd0) ? 16'd1 : time_quantum;
  assign run     = (policy_mode == pss_pkg::POL_RR && p_rem_r > quant) ? quant : p_rem_r;
  assign clk_sum = {1'b0, clock_r} + {17'd0, run};
  assign clk_new = clk_sum[32] ? 32'hFFFF_FFFF : clk_sum[31:0];
  assign rem_new = p_rem_r - run;
  assign done    = (rem_new == 16'd0);
  assign occ_dec = occ_r - CW'(1);
  assign tail    = occ_dec[IW-1:0];
  assign sh_next = sh_r + IW'(1);

  assign sts.full       = (occ_r == CW'(QUEUE_DEPTH));
  assign sts.empty      = (occ_r == '0);
  assign sts.scan_last  = (policy_mode != pss_pkg::POL_PRIO) ||
                          ((CW+1)'(scan_r) + (CW+1)'(1) >= (CW+1)'(occ_r));
  assign sts.shift_last = ((CW+1)'(sh_r) + (CW+1)'(1) >= (CW+1)'(occ_r));

  always_comb begin
    occ_nxt      = occ_r;
    switches_nxt = switches_r;
    if (cmd.add) begin
      occ_nxt = occ_r + CW'(1);
    end
    if (cmd.restart) begin
      switches_nxt = '0;
    end
    if (cmd.finish) begin
      if (done) begin
        occ_nxt = occ_dec;
      end else if (switches_r != 16'hFFFF) begin
        switches_nxt = switches_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= in_action;
      pid_r    <= in_process_id;
      arr_in_r <= in_arrival_time;
      burst_r  <= in_burst_time;
      prio_r   <= in_proc_priority;
      scan_r   <= '0;
      pick_r   <= '0;
      best_r   <= rank_r[0];
    end
    if (cmd.scan && policy_mode == pss_pkg::POL_PRIO) begin
      if (rank_r[scan_r] > best_r) begin
        best_r <= rank_r[scan_r];
        pick_r <= scan_r;
      end
      scan_r <= scan_r + IW'(1);
    end
    if (cmd.take) begin
      p_id_r   <= ident_r[pick_r];
      p_arr_r  <= arrival_r[pick_r];
      p_rem_r  <= remain_r[pick_r];
      p_rank_r <= rank_r[pick_r];
      p_wait_r <= started_r[pick_r] ? wait_r[pick_r]
                                    : ({1'b0, clock_r} - {17'd0, arrival_r[pick_r]});
      sh_r     <= pick_r;
    end
    if (cmd.shift && !sts.shift_last) begin
      ident_r[sh_r]   <= ident_r[sh_next];
      arrival_r[sh_r] <= arrival_r[sh_next];
      remain_r[sh_r]  <= remain_r[sh_next];
      rank_r[sh_r]    <= rank_r[sh_next];
      started_r[sh_r] <= started_r[sh_next];
      wait_r[sh_r]    <= wait_r[sh_next];
      sh_r            <= sh_next;
    end
    if (cmd.add) begin
      ident_r[occ_r[IW-1:0]]   <= pid_r;
      arrival_r[occ_r[IW-1:0]] <= arr_in_r;
      remain_r[occ_r[IW-1:0]]  <= burst_r;
      rank_r[occ_r[IW-1:0]]    <= prio_r;
      started_r[occ_r[IW-1:0]] <= 1'b0;
      wait_r[occ_r[IW-1:0]]    <= '0;
    end
    if (cmd.finish && !done) begin
      ident_r[tail]   <= p_id_r;
      arrival_r[tail] <= p_arr_r;
      remain_r[tail]  <= rem_new;
      rank_r[tail]    <= p_rank_r;
      started_r[tail] <= 1'b1;
      wait_r[tail]    <= p_wait_r;
    end
    if (cmd.finish) begin
      out_status       <= pss_pkg::ST_RAN;
      out_run_id       <= p_id_r;
      out_slice_start  <= clock_r;
      out_slice_length <= run;
      out_time_left    <= rem_new;
      out_finished     <= done;
      out_wait_time    <= p_wait_r;
      out_turnaround   <= done ? ({1'b0, clk_new} - {17'd0, p_arr_r}) : 33'd0;
    end else if (cmd.show) begin
      out_run_id       <= '0;
      out_slice_start  <= '0;
      out_slice_length <= '0;
      out_time_left    <= '0;
      out_finished     <= 1'b0;
      out_wait_time    <= '0;
      out_turnaround   <= '0;
      if (act_r == pss_pkg::ACT_ADD) begin
        out_status <= sts.full ? pss_pkg::ST_FULL : pss_pkg::ST_ADDED;
      end else if (act_r == pss_pkg::ACT_RESTART) begin
        out_status <= pss_pkg::ST_RESTART;
      end else begin
        out_status <= pss_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      clock_r    <= '0;
      switches_r <= '0;
    end else begin
      occ_r      <= occ_nxt;
      switches_r <= switches_nxt;
      if (cmd.finish) begin
        clock_r <= clk_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.show || cmd.finish) begin
      out_switch_count <= switches_nxt;
      out_queue_count  <= occ_nxt;
    end
  end

  `PSS_ASSERT_IMP(a_occ_range, 1'b1, occ_r <= CW'(QUEUE_DEPTH))
  `PSS_ASSERT_IMP(a_add_not_full, cmd.add, !sts.full)
  `PSS_ASSERT_NEXT(a_clock_mono, cmd.finish, clock_r >= $past(clock_r))

endmodule

@@ rtl/pss_ctrl.sv @@
// ----------------------------------------------------------------------------
// Process slice scheduler controller
// Sequences add, scan, compaction and slice steps; owns the handshake.
// ----------------------------------------------------------------------------
`include "process_slice_scheduler_defines.svh"

module pss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       in_action,
  input  pss_pkg::pss_sts_t sts,
  output pss_pkg::pss_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_TAKE, S_SHIFT, S_FINISH, S_OUT
  } state_t;

  state_t     state_r;
  logic [1:0] act_r;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd         = '0;
    cmd.load    = accept;
    cmd.scan    = (state_r == S_SCAN);
    cmd.take    = (state_r == S_TAKE);
    cmd.shift   = (state_r == S_SHIFT);
    cmd.finish  = (state_r == S_FINISH);
    if (state_r == S_DECODE) begin
      case (act_r)
        pss_pkg::ACT_ADD: begin
          cmd.add  = !sts.full;
          cmd.show = 1'b1;
        end
        pss_pkg::ACT_RESTART: begin
          cmd.restart = 1'b1;
          cmd.show    = 1'b1;
        end
        pss_pkg::ACT_DISPATCH: begin
          cmd.show = sts.empty;
        end
        default: begin
          cmd.show = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      act_r     <= pss_pkg::ACT_ADD;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            act_r   <= in_action;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (act_r == pss_pkg::ACT_DISPATCH && !sts.empty) begin
            state_r <= S_SCAN;
          end else begin
            out_valid <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_SCAN: begin
          if (sts.scan_last) begin
            state_r <= S_TAKE;
          end
        end
        S_TAKE: begin
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          if (sts.shift_last) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `PSS_ASSERT_IMP(a_valid_in_out, out_valid, state_r == S_OUT)
  `PSS_ASSERT_NEXT(a_accept_decode, accept, state_r == S_DECODE)
  `PSS_ASSERT_IMP(a_one_step, 1'b1, $onehot0({cmd.scan, cmd.take, cmd.shift, cmd.finish}))

endmodule

@@ rtl/process_slice_scheduler.sv @@
// Add, restart, empty and unused requests pass from decode straight to the output state.
// A dispatch passes through decode, scan, take, shift, finish and output; under priority
// the scan compares one queue slot per step, and in every policy compaction shifts one
// slot per step from the picked one to the tail.
// One item at a time; the next is taken the cycle after its result is taken.
// Synchronous active-low reset empties the queue, clears clock and switch count, restores config.
// ----------------------------------------------------------------------------
// Process slice scheduler
// Ready queue scheduler with round robin, FIFO and priority dispatch.
// ----------------------------------------------------------------------------
module process_slice_scheduler #(
  parameter int QUEUE_DEPTH = pss_pkg::QUEUE_DEPTH_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_process_id,
  input  logic [15:0]       in_arrival_time,
  input  logic [15:0]       in_burst_time,
  input  logic [2:0]        in_proc_priority,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [7:0]        out_run_id,
  output logic [31:0]       out_slice_start,
  output logic [15:0]       out_slice_length,
  output logic [15:0]       out_time_left,
  output logic              out_finished,
  output logic signed [32:0] out_wait_time,
  output logic signed [32:0] out_turnaround,
  output logic [15:0]       out_switch_count,
  output logic [CW-1:0]     out_queue_count
);

  logic [1:0]  policy_r;
  logic [15:0] quantum_r;
  pss_pkg::pss_cmd_t cmd;
  pss_pkg::pss_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= pss_pkg::POL_RR;
      quantum_r <= 16'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        pss_pkg::CFG_POLICY:  policy_r  <= cfg_data[1:0];
        pss_pkg::CFG_QUANTUM: quantum_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd)
  );

  pss_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .policy_mode      (policy_r),
    .time_quantum     (quantum_r),
    .in_action        (in_action),
    .in_process_id    (in_process_id),
    .in_arrival_time  (in_arrival_time),
    .in_burst_time    (in_burst_time),
    .in_proc_priority (in_proc_priority),
    .out_status       (out_status),
    .out_run_id       (out_run_id),
    .out_slice_start  (out_slice_start),
    .out_slice_length (out_slice_length),
    .out_time_left    (out_time_left),
    .out_finished     (out_finished),
    .out_wait_time    (out_wait_time),
    .out_turnaround   (out_turnaround),
    .out_switch_count (out_switch_count),
    .out_queue_count  (out_queue_count)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Process slice scheduler testbench
// Sends add, dispatch, restart and unused requests under every policy and
// varied quanta, predicts each slice from a local ready queue copy, and
// compares every result field, also under random sender and receiver gaps.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] POL_UNUSED = 2'd3;
  localparam int DEPTH = pss_pkg::QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  run_id;
    logic [31:0] slice_start;
    logic [15:0] slice_length;
    logic [15:0] time_left;
    logic        finished;
    logic [32:0] wait_time;
    logic [32:0] turnaround;
    logic [15:0] switch_count;
    logic [4:0]  queue_count;
  } slice_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = pss_pkg::CFG_POLICY;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = pss_pkg::ACT_ADD;
  logic [7:0]  in_process_id = '0;
  logic [15:0] in_arrival_time = '0;
  logic [15:0] in_burst_time = '0;
  logic [2:0]  in_proc_priority = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_run_id;
  logic [31:0] out_slice_start;
  logic [15:0] out_slice_length;
  logic [15:0] out_time_left;
  logic        out_finished;
  logic signed [32:0] out_wait_time;
  logic signed [32:0] out_turnaround;
  logic [15:0] out_switch_count;
  logic [4:0]  out_queue_count;

  process_slice_scheduler i_dut (.*);

  // ready queue copy
  logic [7:0]  rq_id [DEPTH];
  logic [15:0] rq_arrival [DEPTH];
  logic [15:0] rq_remaining [DEPTH];
  logic [2:0]  rq_rank [DEPTH];
  logic        rq_started [DEPTH];
  logic [32:0] rq_wait [DEPTH];
  int          rq_len = 0;
  longint      sim_clock = 0;
  logic [15:0] switch_total = '0;
  logic [1:0]  policy = pss_pkg::POL_RR;
  logic [15:0] quantum = 16'd4;

  slice_report_t pending_reports[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  function automatic slice_report_t schedule_request(logic [1:0] act, logic [7:0] pid,
                                                     logic [15:0] arr, logic [15:0] burst,
                                                     logic [2:0] prio);
    slice_report_t r;
    int pick;
    logic [7:0] id;
    logic [15:0] a, rem, run, q;
    logic [2:0] rank;
    logic [32:0] w;
    r = '0;
    if (act == pss_pkg::ACT_ADD) begin
      if (rq_len >= DEPTH) begin
        r.status = pss_pkg::ST_FULL;
      end else begin
        rq_id[rq_len] = pid;
        rq_arrival[rq_len] = arr;
        rq_remaining[rq_len] = burst;
        rq_rank[rq_len] = prio;
        rq_started[rq_len] = 1'b0;
        rq_wait[rq_len] = '0;
        rq_len++;
        r.status = pss_pkg::ST_ADDED;
      end
    end else if (act == pss_pkg::ACT_RESTART) begin
      switch_total = '0;
      r.status = pss_pkg::ST_RESTART;
    end else if (act == pss_pkg::ACT_DISPATCH && rq_len > 0) begin
      pick = 0;
      if (policy == pss_pkg::POL_PRIO)
        for (int i = 1; i < rq_len; i++)
          if (rq_rank[i] > rq_rank[pick]) pick = i;
      id = rq_id[pick];
      a = rq_arrival[pick];
      rem = rq_remaining[pick];
      rank = rq_rank[pick];
      w = rq_started[pick] ? rq_wait[pick] : 33'(sim_clock) - 33'(a);
      for (int i = pick; i + 1 < rq_len; i++) begin
        rq_id[i] = rq_id[i+1];
        rq_arrival[i] = rq_arrival[i+1];
        rq_remaining[i] = rq_remaining[i+1];
        rq_rank[i] = rq_rank[i+1];
        rq_started[i] = rq_started[i+1];
        rq_wait[i] = rq_wait[i+1];
      end
      rq_len--;
      run = rem;
      if (policy == pss_pkg::POL_RR) begin
        q = (quantum == 0) ? 16'd1 : quantum;
        if (run > q) run = q;
      end
      r.slice_start = sim_clock[31:0];
      sim_clock = sim_clock + run;
      if (sim_clock > 64'hFFFF_FFFF) sim_clock = 64'hFFFF_FFFF;
      rem = rem - run;
      if (rem == 0) begin
        r.turnaround = 33'(sim_clock) - 33'(a);
      end else begin
        rq_id[rq_len] = id;
        rq_arrival[rq_len] = a;
        rq_remaining[rq_len] = rem;
        rq_rank[rq_len] = rank;
        rq_started[rq_len] = 1'b1;
        rq_wait[rq_len] = w;
        rq_len++;
        if (switch_total != 16'hFFFF) switch_total++;
      end
      r.status = pss_pkg::ST_RAN;
      r.run_id = id;
      r.slice_length = run;
      r.time_left = rem;
      r.finished = (rem == 0);
      r.wait_time = w;
    end else begin
      r.status = pss_pkg::ST_EMPTY;
    end
    r.switch_count = switch_total;
    r.queue_count = 5'(rq_len);
    return r;
  endfunction

  task automatic send_request(logic [1:0] act, logic [7:0] pid, logic [15:0] arr,
                              logic [15:0] burst, logic [2:0] prio);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_process_id <= pid;
    in_arrival_time <= arr;
    in_burst_time <= burst;
    in_proc_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.insert(pending_reports.size(),
                           schedule_request(act, pid, arr, burst, prio));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pss_pkg::CFG_POLICY) policy = value[1:0];
    else quantum = value;
  endtask

  task automatic report_field(string name, logic [32:0] exp_v, logic [32:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    slice_report_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual status %h", $time, out_status);
      end else begin
        e = pending_reports.pop_front();
        report_field("status", e.status, out_status);
        report_field("run_id", e.run_id, out_run_id);
        report_field("slice_start", e.slice_start, out_slice_start);
        report_field("slice_length", e.slice_length, out_slice_length);
        report_field("time_left", e.time_left, out_time_left);
        report_field("finished", e.finished, out_finished);
        report_field("wait_time", e.wait_time, out_wait_time);
        report_field("turnaround", e.turnaround, out_turnaround);
        report_field("switch_count", e.switch_count, out_switch_count);
        report_field("queue_count", e.queue_count, out_queue_count);
      end
    end
  end

  task automatic test_empty_queue();
    send_request(pss_pkg::ACT_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
    send_request(ACT_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
    send_request(pss_pkg::ACT_RESTART, 8'h00, 16'h0000, 16'h0000, 3'd0);
  endtask

  task automatic test_full_queue();
    send_request(pss_pkg::ACT_ADD, 8'h00, 16'h0000, 16'h0000, 3'd0);
    send_request(pss_pkg::ACT_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
    send_request(pss_pkg::ACT_ADD, 8'h11, 16'h0000, 16'h0001, 3'd6);
    for (int i = 3; i < DEPTH; i++)
      send_request(pss_pkg::ACT_ADD, 8'(i), 16'(i), 16'(i + 2), 3'(1 + i % 5));
    send_request(pss_pkg::ACT_ADD, 8'hAA, 16'h5555, 16'hAAAA, 3'd5);
  endtask

  task automatic test_policies();
    write_reg(pss_pkg::CFG_POLICY, 16'(pss_pkg::POL_PRIO));
    repeat (2) send_request(pss_pkg::ACT_DISPATCH, '0, '0, '0, '0);
    write_reg(pss_pkg::CFG_POLICY, 16'(pss_pkg::POL_FIFO));
    send_request(pss_pkg::ACT_DISPATCH, '0, '0, '0, '0);
    write_reg(pss_pkg::CFG_POLICY, 16'(POL_UNUSED));
    send_request(pss_pkg::ACT_DISPATCH, '0, '0, '0, '0);
    write_reg(pss_pkg::CFG_POLICY, 16'(pss_pkg::POL_RR));
    write_reg(pss_pkg::CFG_QUANTUM, 16'd0);
    repeat (2) send_request(pss_pkg::ACT_DISPATCH, '0, '0, '0, '0);
  endtask

  task automatic test_random(int count);
    int r;
    logic [1:0] act;
    logic [15:0] burst;
    logic [2:0] prio;
    for (int n = 0; n < count; n++) begin
      if (n % 120 == 0) begin
        write_reg(pss_pkg::CFG_POLICY, 16'($urandom_range(3)));
        case ($urandom_range(3))
          0: write_reg(pss_pkg::CFG_QUANTUM, 16'hFFFF);
          1: write_reg(pss_pkg::CFG_QUANTUM, 16'($urandom_range(1)));
          2: write_reg(pss_pkg::CFG_QUANTUM, 16'($urandom));
          default: write_reg(pss_pkg::CFG_QUANTUM, 16'($urandom_range(2, 9)));
        endcase
      end
      if ($urandom_range(199) == 0) wait_idle();
      r = $urandom_range(99);
      if (r < 2) act = ACT_UNUSED;
      else if (r < 6) act = pss_pkg::ACT_RESTART;
      else if ($urandom_range(16) > rq_len || $urandom_range(9) == 0) act = pss_pkg::ACT_ADD;
      else act = pss_pkg::ACT_DISPATCH;
      burst = ($urandom_range(9) < 7) ? 16'($urandom_range(12)) : 16'($urandom);
      prio = ($urandom_range(99) < 85) ? 3'($urandom_range(1, 5)) : 3'($urandom_range(7));
      send_request(act, 8'($urandom), 16'($urandom), burst, prio);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_full_queue();
    test_policies();
    send_idle_pct = 0;   stall_pct = 0;  test_random(480);
    send_idle_pct = 64;  stall_pct = 0;  test_random(480);
    send_idle_pct = 0;   stall_pct = 64; test_random(480);
    send_idle_pct = 37;  stall_pct = 37; test_random(480);
    wait_idle();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pss_pkg.sv
rtl/pss_datapath.sv
rtl/pss_ctrl.sv
rtl/process_slice_scheduler.sv
sim/testbench.sv
